// ----- hdl/sdec_pkg.sv -----
// ----------------------------------------------------------------------------
// sdec_pkg: shared types and constants for the decimal text converter
// Widths of the binary and BCD words, ASCII codes and the controller states.
// ----------------------------------------------------------------------------
package sdec_pkg;

  localparam int VALUE_W     = 64;
  localparam int BCD_DIGITS  = 20;
  localparam int BCD_W       = 4 * BCD_DIGITS;
  localparam int NDIG_W      = $clog2(BCD_DIGITS + 1);
  localparam int BIT_CNT_W   = $clog2(VALUE_W);
  localparam int CHAR_W      = 8;

  // Width of the text field; one slot of it is kept free.
  localparam int FIELD_WIDTH = 16;
  localparam int SLOTS       = FIELD_WIDTH - 1;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SCAN,
    S_SIGN,
    S_EMIT,
    S_OVF
  } state_t;

endpackage

// ----- hdl/signed_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// signed_to_decimal_ascii: signed 64-bit integer to decimal ASCII text
// Takes one value per input beat and sends its text, one character per
// output beat, most significant character first.
//
// The input channel carries in_value; the output channel carries
// out_character, out_last and out_overflow. Negative values get a leading
// minus sign, and zero gives a single '0'. Text longer than FIELD_WIDTH-1
// slots is replaced by one beat with out_overflow and out_last set and a
// NUL character. The most negative value converts as magnitude 2^63.
// An item is taken in idle, passes through the bit-serial BCD converter and
// its BCD word is taken; then leading zero digits are dropped one at a time
// (up to 19), a decision step follows and one character is sent per beat.
// A new value is taken only once the last beat of the previous one is in
// the output register. When the receiver stalls, the output register holds
// its beat and the character sequencer waits. Reset empties the output
// register and returns the block to idle.
// ----------------------------------------------------------------------------
module signed_to_decimal_ascii #(
  parameter int FIELD_WIDTH = sdec_pkg::FIELD_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [sdec_pkg::VALUE_W-1:0] in_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sdec_pkg::CHAR_W-1:0]     out_character,
  output logic                            out_last,
  output logic                            out_overflow
);

  localparam int SLOTS = FIELD_WIDTH - 1;

  sdec_pkg::state_t                 state_r, state_nxt;
  logic [sdec_pkg::BCD_W-1:0]       digits_r, digits_nxt;
  logic [sdec_pkg::NDIG_W-1:0]      ndig_r, ndig_nxt;
  logic                             neg_r, neg_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [sdec_pkg::CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                             out_last_r, out_last_nxt;
  logic                             out_ovf_r, out_ovf_nxt;

  logic                             conv_start;
  logic                             conv_done;
  logic [sdec_pkg::BCD_W-1:0]       conv_bcd;
  logic [sdec_pkg::VALUE_W-1:0]     mag;
  logic                             out_free;
  logic [3:0]                       top_digit;
  logic [sdec_pkg::NDIG_W:0]        total;

  assign mag = in_value[sdec_pkg::VALUE_W-1] ? (~in_value + sdec_pkg::VALUE_W'(1)) : in_value;

  sdec_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .mag   (mag),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign top_digit = digits_r[sdec_pkg::BCD_W-1 -: 4];
  assign total     = {1'b0, ndig_r} + {{sdec_pkg::NDIG_W{1'b0}}, neg_r};

  always_comb begin
    state_nxt     = state_r;
    digits_nxt    = digits_r;
    ndig_nxt      = ndig_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    conv_start    = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      sdec_pkg::S_IDLE: begin
        if (in_valid) begin
          neg_nxt    = in_value[sdec_pkg::VALUE_W-1];
          conv_start = 1'b1;
          state_nxt  = sdec_pkg::S_CONV;
        end
      end
      sdec_pkg::S_CONV: begin
        if (conv_done) begin
          digits_nxt = conv_bcd;
          ndig_nxt   = sdec_pkg::NDIG_W'(sdec_pkg::BCD_DIGITS);
          state_nxt  = sdec_pkg::S_SCAN;
        end
      end
      sdec_pkg::S_SCAN: begin
        if (top_digit == 4'd0 && ndig_r > sdec_pkg::NDIG_W'(1)) begin
          digits_nxt = {digits_r[sdec_pkg::BCD_W-5:0], 4'd0};
          ndig_nxt   = ndig_r - sdec_pkg::NDIG_W'(1);
        end else if (total > (sdec_pkg::NDIG_W + 1)'(SLOTS)) begin
          state_nxt = sdec_pkg::S_OVF;
        end else if (neg_r) begin
          state_nxt = sdec_pkg::S_SIGN;
        end else begin
          state_nxt = sdec_pkg::S_EMIT;
        end
      end
      sdec_pkg::S_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = sdec_pkg::CHAR_MINUS;
          out_last_nxt  = 1'b0;
          out_ovf_nxt   = 1'b0;
          state_nxt     = sdec_pkg::S_EMIT;
        end
      end
      sdec_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = sdec_pkg::CHAR_ZERO + {4'd0, top_digit};
          out_last_nxt  = (ndig_r == sdec_pkg::NDIG_W'(1));
          out_ovf_nxt   = 1'b0;
          digits_nxt    = {digits_r[sdec_pkg::BCD_W-5:0], 4'd0};
          ndig_nxt      = ndig_r - sdec_pkg::NDIG_W'(1);
          if (ndig_r == sdec_pkg::NDIG_W'(1)) begin
            state_nxt = sdec_pkg::S_IDLE;
          end
        end
      end
      sdec_pkg::S_OVF: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = sdec_pkg::CHAR_NUL;
          out_last_nxt  = 1'b1;
          out_ovf_nxt   = 1'b1;
          state_nxt     = sdec_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sdec_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sdec_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digits_r   <= digits_nxt;
    ndig_r     <= ndig_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign in_ready      = (state_r == sdec_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;
  assign out_overflow  = out_ovf_r;

endmodule

// ----- hdl/sdec_dabble.sv -----
// ----------------------------------------------------------------------------
// sdec_dabble: serial binary to BCD converter
// Shifts the magnitude in one bit per cycle, correcting each BCD digit by
// adding three when it is five or more before every shift.
// ----------------------------------------------------------------------------
module sdec_dabble (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sdec_pkg::VALUE_W-1:0]  mag,
  output logic                          done,
  output logic [sdec_pkg::BCD_W-1:0]    bcd
);

  logic [sdec_pkg::VALUE_W-1:0]   bin_r, bin_nxt;
  logic [sdec_pkg::BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [sdec_pkg::BIT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [sdec_pkg::BCD_W-1:0]     adj;

  always_comb begin
    for (int i = 0; i < sdec_pkg::BCD_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt  = mag;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bin_nxt = {bin_r[sdec_pkg::VALUE_W-2:0], 1'b0};
      bcd_nxt = {adj[sdec_pkg::BCD_W-2:0], bin_r[sdec_pkg::VALUE_W-1]};
      cnt_nxt = cnt_r + sdec_pkg::BIT_CNT_W'(1);
      if (cnt_r == sdec_pkg::BIT_CNT_W'(sdec_pkg::VALUE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

// ----- tb/sdec_text_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sdec_text_checker: beat-level checker for the decimal text converter
// Watches both channels. For every accepted value it works out the expected
// text as a queue of character beats, then compares every output beat with
// the oldest of them field by field.
// ----------------------------------------------------------------------------
module sdec_text_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [sdec_pkg::VALUE_W-1:0] in_value,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [sdec_pkg::CHAR_W-1:0]         out_character,
  input  logic                                out_last,
  input  logic                                out_overflow,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  values_taken,
  output int                                  overflow_values,
  output int                                  beats_checked
);

  typedef struct packed {
    logic [sdec_pkg::CHAR_W-1:0] character;
    logic                        last;
    logic                        overflow;
  } char_beat_t;

  char_beat_t expected_text[$];

  function automatic void queue_decimal_text(input logic [sdec_pkg::VALUE_W-1:0] value);
    logic [sdec_pkg::VALUE_W-1:0] mag;
    logic [sdec_pkg::CHAR_W-1:0]  digits[$];
    logic                         neg;
    neg = value[sdec_pkg::VALUE_W-1];
    mag = neg ? (~value + 64'd1) : value;
    do begin
      digits.push_front(sdec_pkg::CHAR_ZERO + sdec_pkg::CHAR_W'(mag % 64'd10));
      mag = mag / 64'd10;
    end while (mag != 0);
    if (digits.size() + int'(neg) > sdec_pkg::SLOTS) begin
      expected_text.push_back('{sdec_pkg::CHAR_NUL, 1'b1, 1'b1});
      overflow_values++;
    end else begin
      if (neg) expected_text.push_back('{sdec_pkg::CHAR_MINUS, 1'b0, 1'b0});
      foreach (digits[i])
        expected_text.push_back('{digits[i], i == digits.size() - 1, 1'b0});
    end
  endfunction

  always @(posedge clk) begin
    char_beat_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          $error("Unexpected beat: character %h last %b overflow %b",
                 out_character, out_last, out_overflow);
          fail_count++;
        end else begin
          want = expected_text.pop_front();
          beats_checked++;
          if (out_character !== want.character) begin
            $error("character: expected %h, got %h", want.character, out_character);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_last);
            fail_count++;
          end
          if (out_overflow !== want.overflow) begin
            $error("overflow: expected %b, got %b", want.overflow, out_overflow);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        queue_decimal_text(in_value);
        values_taken++;
      end
      pending = expected_text.size();
    end
  end

endmodule

// ----- tb/tb_signed_to_decimal_ascii.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_to_decimal_ascii: testbench for the decimal text converter
// Sends a directed set of boundary values followed by random values, most of
// them short enough to fit the field and many of the rest too wide, with random gaps
// on the input and random stalls on the output. A separate checker predicts
// and compares every character beat.
// ----------------------------------------------------------------------------
module tb_signed_to_decimal_ascii;

  localparam int RANDOM_VALUES = 260;
  localparam int CYCLE_LIMIT   = 600000;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic signed [sdec_pkg::VALUE_W-1:0] in_value;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [sdec_pkg::CHAR_W-1:0]         out_character;
  logic                                out_last;
  logic                                out_overflow;
  logic                                calm;
  int                                  fail_count;
  int                                  pending;
  int                                  values_taken;
  int                                  overflow_values;
  int                                  beats_checked;
  int                                  cycles = 0;

  logic signed [sdec_pkg::VALUE_W-1:0] boundary_values[$] = '{
    64'sd0, 64'sd1, -64'sd1, 64'sd9, -64'sd9, 64'sd10, -64'sd10, 64'sd42,
    -64'sd100, 64'sd99999999999999, -64'sd99999999999999,
    -64'sd100000000000000, 64'sd999999999999999, 64'sd1000000000000000,
    64'sd1234567890, -64'sd987654321,
    64'sh7FFF_FFFF_FFFF_FFFF, 64'sh8000_0000_0000_0000,
    64'sh8000_0000_0000_0001, 64'sh5555_5555_5555_5555,
    64'shAAAA_AAAA_AAAA_AAAA
  };

  signed_to_decimal_ascii dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last),
    .out_overflow  (out_overflow)
  );

  sdec_text_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_character   (out_character),
    .out_last        (out_last),
    .out_overflow    (out_overflow),
    .fail_count      (fail_count),
    .pending         (pending),
    .values_taken    (values_taken),
    .overflow_values (overflow_values),
    .beats_checked   (beats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 15);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_signed_to_decimal_ascii: errors");
      $finish;
    end
  end

  // Picks a digit count first so that short texts dominate; some values are
  // raw 64-bit patterns and some are deliberately too wide.
  function automatic logic [sdec_pkg::VALUE_W-1:0] pick_value();
    logic [sdec_pkg::VALUE_W-1:0] lo;
    logic [sdec_pkg::VALUE_W-1:0] hi;
    logic [sdec_pkg::VALUE_W-1:0] mag;
    logic [sdec_pkg::VALUE_W-1:0] r;
    int unsigned                  ndig;
    int unsigned                  sel;
    sel = $urandom_range(99);
    r   = {$urandom, $urandom};
    if (sel < 12) return r;
    ndig = (sel < 80) ? $urandom_range(1, sdec_pkg::SLOTS)
                      : $urandom_range(sdec_pkg::SLOTS, 19);
    lo = 64'd1;
    for (int i = 1; i < ndig; i++) lo = lo * 64'd10;
    hi = lo * 64'd10 - 64'd1;
    if (ndig == 1) lo = 64'd0;
    mag = lo + r % (hi - lo + 64'd1);
    if (mag > 64'h8000_0000_0000_0000) mag = 64'h8000_0000_0000_0000;
    if ($urandom_range(1) == 1) return -mag;
    if (mag[sdec_pkg::VALUE_W-1]) mag = 64'h7FFF_FFFF_FFFF_FFFF;
    return mag;
  endfunction

  task automatic send_value(input logic [sdec_pkg::VALUE_W-1:0] value);
    int gap;
    gap = (!calm && $urandom_range(99) < 15) ? $urandom_range(1, 90) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_value = value;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    calm     = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (boundary_values[i]) send_value(boundary_values[i]);
    for (int n = 0; n < RANDOM_VALUES; n++) begin
      calm = (n >= 120 && n < 170);
      send_value(pick_value());
    end
    calm     = 1'b0;
    in_valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);

    $display("Converted %0d values, %0d of them too wide for the field.",
             values_taken, overflow_values);
    $display("Checked %0d character beats under random gaps and stalls.", beats_checked);
    if (fail_count == 0)
      $display("tb_signed_to_decimal_ascii: clean");
    else
      $display("tb_signed_to_decimal_ascii: errors");
    $finish;
  end

endmodule

// ----- signed_to_decimal_ascii.f -----
hdl/sdec_pkg.sv
hdl/sdec_dabble.sv
hdl/signed_to_decimal_ascii.sv
tb/sdec_text_checker.sv
tb/tb_signed_to_decimal_ascii.sv
